// ===== hdl/sbm_pkg.sv =====
// Shared constants, types and helper functions of the SAD stereo disparity block.
package sbm_pkg;

   localparam int MAX_WIDTH     = 1024;
   localparam int MAX_HEIGHT    = 1024;
   localparam int MAX_RADIUS    = 7;
   localparam int MAX_DISPARITY = 64;

   localparam int STORE_ROWS  = 2 * MAX_RADIUS + 1;
   localparam int STORE_DEPTH = STORE_ROWS * MAX_WIDTH;

   localparam int PIX_W     = 8;
   localparam int DISP_W    = 6;
   localparam int CSR_W     = 11;
   localparam int CSR_IDX_W = 2;
   localparam int CW_W      = 11;
   localparam int CH_W      = 11;
   localparam int CR_W      = 3;
   localparam int CD_W      = 7;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int WSZ_W  = COL_W + 1;
   localparam int HSZ_W  = ROW_W + 1;
   localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
   localparam int DCNT_W = $clog2(MAX_DISPARITY + 1);
   localparam int K_W    = $clog2(MAX_DISPARITY);
   localparam int SLOT_W = $clog2(STORE_ROWS);
   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam int X_W    = $clog2(MAX_WIDTH + MAX_DISPARITY) + 1;
   localparam int COST_W = $clog2(STORE_ROWS * STORE_ROWS * 255 + 1);

   localparam int COST_PER_TAP = 50;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH     = 2'd0,
      CSR_IMAGE_HEIGHT    = 2'd1,
      CSR_WINDOW_RADIUS   = 2'd2,
      CSR_DISPARITY_COUNT = 2'd3
   } csr_index_type;

   // Controls broadcast from the sequencer to every cell of the chain.
   typedef struct packed {
      logic             clear;
      logic             accumulate;
      logic             shift_cost;
      logic [PIX_W-1:0] left_pixel;
   } cell_ctrl_type;

   // Tags that travel with a store read through the pipeline.
   typedef struct packed {
      logic active;
      logic rvalid;
      logic luse;
   } issue_type;

   // Cost threshold for a window of side 2*rad+1.
   function automatic logic [COST_W-1:0] cost_limit(input logic [RAD_W-1:0] rad);
      logic [COST_W-1:0] side;
      side = COST_W'({rad, 1'b1});
      return COST_W'(COST_PER_TAP * side * side);
   endfunction

   function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

// ===== hdl/sbm_ifs.sv =====
// Stream interfaces of the pixel request and disparity response channels.
interface sbm_req_if import sbm_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             mode;
   logic [PIX_W-1:0] left_pixel;
   logic [PIX_W-1:0] right_pixel;

   modport source (output valid, mode, left_pixel, right_pixel, input ready);
   modport sink   (input valid, mode, left_pixel, right_pixel, output ready);
endinterface

interface sbm_rsp_if import sbm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DISP_W-1:0] disparity;
   logic              last_of_frame;

   modport source (output valid, disparity, last_of_frame, input ready);
   modport sink   (input valid, disparity, last_of_frame, output ready);
endinterface

// ===== hdl/sbm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sbm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     write_en,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data_ff <= mem_ff[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

// ===== hdl/sbm_cell.sv =====
// One disparity cell: holds a delayed right pixel and the running SAD cost.
module sbm_cell import sbm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cell_ctrl_type       ctrl,
   input  logic [PIX_W-1:0]    prev_pixel,
   input  logic                prev_valid,
   input  logic [COST_W-1:0]   next_cost,
   output logic [PIX_W-1:0]    pixel,
   output logic                valid,
   output logic [COST_W-1:0]   cost
);

   logic [PIX_W-1:0]  pixel_ff;
   logic              valid_ff;
   logic [COST_W-1:0] cost_ff;
   logic [COST_W-1:0] cost_in;

   // The right pixel moves one cell further every cycle.
   always_ff @(posedge clock) begin
      pixel_ff <= prev_pixel;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= prev_valid;
      end
   end

   // Clear the cost, accumulate the absolute difference, or pass costs toward the picker.
   always_comb begin
      cost_in = cost_ff;
      if (ctrl.clear) begin
         cost_in = '0;
      end else if (ctrl.accumulate && valid_ff) begin
         cost_in = cost_ff + COST_W'(abs_diff(ctrl.left_pixel, pixel_ff));
      end else if (ctrl.shift_cost) begin
         cost_in = next_cost;
      end
   end

   always_ff @(posedge clock) begin
      cost_ff <= cost_in;
   end

   assign pixel = pixel_ff;
   assign valid = valid_ff;
   assign cost  = cost_ff;

endmodule

// ===== hdl/sad_block_matching_disparity_top.sv =====
// Top level of the SAD block-matching stereo disparity block.
//
//   channel   dir  handshake      payload
//   req_chan  in   valid/ready    mode, left_pixel, right_pixel
//   rsp_chan  out  valid/ready    disparity, last_of_frame
//   csr_*     in   csr_write_en   csr_index, csr_write_data
//
// When no result is due, an item passes ST_IDLE and ST_CHECK. When a result is
// due it goes on through ST_SCAN, which reads the line stores row by row over
// the clipped window, ST_DRAIN, ST_PICK, where the costs are handed along the
// cell chain, and ST_RESULT.
// Reset is synchronous; the line stores are not cleared.
// A result waits in the output register; a stalled response only holds the
// block once the next result is ready to be loaded.
module sad_block_matching_disparity_top import sbm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   sbm_req_if.sink              req_chan,
   sbm_rsp_if.source            rsp_chan,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_write_data
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_CHECK  = 6'b000010,
      ST_SCAN   = 6'b000100,
      ST_DRAIN  = 6'b001000,
      ST_PICK   = 6'b010000,
      ST_RESULT = 6'b100000
   } state_type;

   // Configuration registers.
   logic [CW_W-1:0] csr_width_ff;
   logic [CH_W-1:0] csr_height_ff;
   logic [CR_W-1:0] csr_radius_ff;
   logic [CD_W-1:0] csr_dcount_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_width_ff  <= CW_W'(640);
         csr_height_ff <= CH_W'(480);
         csr_radius_ff <= CR_W'(3);
         csr_dcount_ff <= CD_W'(64);
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:     csr_width_ff  <= csr_write_data[CW_W-1:0];
            CSR_IMAGE_HEIGHT:    csr_height_ff <= csr_write_data[CH_W-1:0];
            CSR_WINDOW_RADIUS:   csr_radius_ff <= csr_write_data[CR_W-1:0];
            CSR_DISPARITY_COUNT: csr_dcount_ff <= csr_write_data[CD_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective sizes after clamping.
   logic [WSZ_W-1:0]  eff_w;
   logic [HSZ_W-1:0]  eff_h;
   logic [RAD_W-1:0]  eff_r;
   logic [DCNT_W-1:0] eff_d;

   always_comb begin
      if (csr_width_ff == '0) eff_w = WSZ_W'(1);
      else if (csr_width_ff > MAX_WIDTH) eff_w = WSZ_W'(MAX_WIDTH);
      else eff_w = WSZ_W'(csr_width_ff);
      if (csr_height_ff == '0) eff_h = HSZ_W'(1);
      else if (csr_height_ff > MAX_HEIGHT) eff_h = HSZ_W'(MAX_HEIGHT);
      else eff_h = HSZ_W'(csr_height_ff);
      if (csr_radius_ff > MAX_RADIUS) eff_r = RAD_W'(MAX_RADIUS);
      else eff_r = RAD_W'(csr_radius_ff);
      if (csr_dcount_ff > MAX_DISPARITY) eff_d = DCNT_W'(MAX_DISPARITY);
      else eff_d = DCNT_W'(csr_dcount_ff);
   end

   // Sequencer and position registers.
   state_type         state_ff, state_in;
   logic [COL_W-1:0]  in_col_ff, in_col_in;
   logic [ROW_W-1:0]  in_row_ff, in_row_in;
   logic [SLOT_W-1:0] in_slot_ff, in_slot_in;
   logic [COL_W-1:0]  out_col_ff, out_col_in;
   logic [ROW_W-1:0]  out_row_ff, out_row_in;
   logic [SLOT_W-1:0] out_slot_ff, out_slot_in;
   logic              frame_done_ff, frame_done_in;

   // Window scan registers.
   logic [ROW_W-1:0]  rr_ff, rr_in;
   logic [ROW_W-1:0]  r1_ff, r1_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [COL_W-1:0]  c0_ff, c0_in;
   logic [COL_W-1:0]  c1_ff, c1_in;
   logic [X_W-1:0]    x_ff, x_in;
   logic              drain_ff, drain_in;
   logic [K_W-1:0]    k_ff, k_in;
   logic [COST_W-1:0] best_ff, best_in;
   logic [K_W-1:0]    win_ff, win_in;
   logic              clear_cells;

   // Response register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DISP_W-1:0] rsp_disp_ff, rsp_disp_in;
   logic              rsp_last_ff, rsp_last_in;

   // Store access.
   logic              store_we;
   logic [ADDR_W-1:0] store_waddr;
   logic [ADDR_W-1:0] store_raddr;
   logic [PIX_W-1:0]  left_q;
   logic [PIX_W-1:0]  right_q;
   issue_type         issue;
   issue_type         p1_ff;
   issue_type         p2_ff;
   logic [PIX_W-1:0]  left_ff;

   // Cell chain wiring.
   logic [PIX_W-1:0]  chain_pixel [MAX_DISPARITY+1];
   logic              chain_valid [MAX_DISPARITY+1];
   logic [COST_W-1:0] chain_cost  [MAX_DISPARITY+1];
   cell_ctrl_type     cell_ctrl;

   logic req_fire;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_comb begin
      logic [WSZ_W-1:0]   col_next;
      logic [HSZ_W-1:0]   row_next;
      logic [HSZ_W:0]     nr_sum;
      logic [WSZ_W:0]     nc_sum;
      logic [ROW_W-1:0]   nr;
      logic [COL_W-1:0]   nc;
      logic               due;
      logic [ROW_W-1:0]   r0;
      logic [COL_W-1:0]   c0;
      logic [RAD_W-1:0]   back;
      logic [WSZ_W+1:0]   reach;
      logic               cand;
      logic [COST_W-1:0]  cost0;
      logic               rsp_free;

      state_in      = state_ff;
      in_col_in     = in_col_ff;
      in_row_in     = in_row_ff;
      in_slot_in    = in_slot_ff;
      out_col_in    = out_col_ff;
      out_row_in    = out_row_ff;
      out_slot_in   = out_slot_ff;
      frame_done_in = frame_done_ff;
      rr_in         = rr_ff;
      r1_in         = r1_ff;
      slot_in       = slot_ff;
      c0_in         = c0_ff;
      c1_in         = c1_ff;
      x_in          = x_ff;
      drain_in      = drain_ff;
      k_in          = k_ff;
      best_in       = best_ff;
      win_in        = win_ff;
      clear_cells   = 1'b0;
      rsp_disp_in   = rsp_disp_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_free      = !rsp_valid_ff || rsp_chan.ready;
      store_we      = 1'b0;
      store_waddr   = ADDR_W'(in_slot_ff) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_col_ff);
      store_raddr   = ADDR_W'(slot_ff) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x_ff[COL_W-1:0]);
      issue         = '0;

      col_next = WSZ_W'(in_col_ff) + WSZ_W'(1);
      row_next = HSZ_W'(in_row_ff) + HSZ_W'(1);
      nr_sum   = (HSZ_W+1)'(out_row_ff) + (HSZ_W+1)'(eff_r);
      nc_sum   = (WSZ_W+1)'(out_col_ff) + (WSZ_W+1)'(eff_r);
      nr       = (nr_sum < (HSZ_W+1)'(eff_h)) ? nr_sum[ROW_W-1:0]
                                               : ROW_W'(eff_h - HSZ_W'(1));
      nc       = (nc_sum < (WSZ_W+1)'(eff_w)) ? nc_sum[COL_W-1:0]
                                               : COL_W'(eff_w - WSZ_W'(1));
      due      = frame_done_ff || (in_row_ff > nr) ||
                 ((in_row_ff == nr) && (in_col_ff > nc));
      r0       = (out_row_ff >= ROW_W'(eff_r)) ? out_row_ff - ROW_W'(eff_r) : '0;
      c0       = (out_col_ff >= COL_W'(eff_r)) ? out_col_ff - COL_W'(eff_r) : '0;
      back     = RAD_W'(out_row_ff - r0);
      reach    = (WSZ_W+2)'(out_col_ff) + (WSZ_W+2)'(k_ff);
      cand     = ((DCNT_W)'(k_ff) < eff_d) && (reach <= (WSZ_W+2)'(eff_w));
      cost0    = chain_cost[0];

      unique case (state_ff)
         // Take one transaction; a pixel transaction (mode 0) writes its pixels into the line stores.
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_CHECK;
               if (!req_chan.mode) begin
                  store_we = 1'b1;
                  if (frame_done_ff) begin
                     out_col_in    = '0;
                     out_row_in    = '0;
                     out_slot_in   = '0;
                     frame_done_in = 1'b0;
                  end
                  if (col_next >= eff_w) begin
                     in_col_in = '0;
                     if (row_next >= eff_h) begin
                        in_row_in     = '0;
                        in_slot_in    = '0;
                        frame_done_in = 1'b1;
                     end else begin
                        in_row_in  = row_next[ROW_W-1:0];
                        in_slot_in = (in_slot_ff == SLOT_W'(STORE_ROWS - 1)) ? '0
                                     : in_slot_ff + SLOT_W'(1);
                     end
                  end else begin
                     in_col_in = col_next[COL_W-1:0];
                  end
               end
            end
         end
         // Decide whether the next output window is complete and set up the scan.
         ST_CHECK: begin
            if (!due) begin
               state_in = ST_IDLE;
            end else begin
               state_in    = ST_SCAN;
               clear_cells = 1'b1;
               rr_in       = r0;
               r1_in       = nr;
               c0_in       = c0;
               c1_in       = nc;
               slot_in     = (out_slot_ff >= SLOT_W'(back)) ? out_slot_ff - SLOT_W'(back)
                             : out_slot_ff + SLOT_W'(STORE_ROWS) - SLOT_W'(back);
               x_in        = X_W'(c0) - X_W'(MAX_DISPARITY - 1);
            end
         end
         // Stream one window row per pass, primed with the preceding columns.
         ST_SCAN: begin
            issue.active = 1'b1;
            issue.rvalid = !x_ff[X_W-1];
            issue.luse   = $signed(x_ff) >= $signed(X_W'(c0_ff));
            if (x_ff == X_W'(c1_ff)) begin
               if (rr_ff == r1_ff) begin
                  state_in = ST_DRAIN;
                  drain_in = 1'b0;
               end else begin
                  rr_in   = rr_ff + ROW_W'(1);
                  slot_in = (slot_ff == SLOT_W'(STORE_ROWS - 1)) ? '0 : slot_ff + SLOT_W'(1);
                  x_in    = X_W'(c0_ff) - X_W'(MAX_DISPARITY - 1);
               end
            end else begin
               x_in = x_ff + X_W'(1);
            end
         end
         // Let the last reads reach the accumulators.
         ST_DRAIN: begin
            drain_in = 1'b1;
            if (drain_ff) begin
               state_in = ST_PICK;
               k_in     = '0;
               best_in  = cost_limit(eff_r);
               win_in   = '0;
            end
         end
         // Costs leave the chain one per cycle; keep the first strict minimum.
         ST_PICK: begin
            if (cand && (cost0 < best_ff)) begin
               best_in = cost0;
               win_in  = k_ff;
            end
            k_in = k_ff + K_W'(1);
            if (k_ff == K_W'(MAX_DISPARITY - 1)) begin
               state_in = ST_RESULT;
            end
         end
         // Load the response register and advance the output position.
         ST_RESULT: begin
            if (rsp_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_disp_in  = DISP_W'(win_ff);
               rsp_last_in  = 1'b0;
               if (WSZ_W'(out_col_ff) + WSZ_W'(1) >= eff_w) begin
                  out_col_in = '0;
                  if (HSZ_W'(out_row_ff) + HSZ_W'(1) >= eff_h) begin
                     out_row_in    = '0;
                     out_slot_in   = '0;
                     rsp_last_in   = 1'b1;
                     frame_done_in = 1'b0;
                  end else begin
                     out_row_in  = out_row_ff + ROW_W'(1);
                     out_slot_in = (out_slot_ff == SLOT_W'(STORE_ROWS - 1)) ? '0
                                   : out_slot_ff + SLOT_W'(1);
                  end
               end else begin
                  out_col_in = out_col_ff + COL_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         in_col_ff     <= '0;
         in_row_ff     <= '0;
         in_slot_ff    <= '0;
         out_col_ff    <= '0;
         out_row_ff    <= '0;
         out_slot_ff   <= '0;
         frame_done_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         drain_ff      <= 1'b0;
         p1_ff         <= '0;
         p2_ff         <= '0;
      end else begin
         state_ff      <= state_in;
         in_col_ff     <= in_col_in;
         in_row_ff     <= in_row_in;
         in_slot_ff    <= in_slot_in;
         out_col_ff    <= out_col_in;
         out_row_ff    <= out_row_in;
         out_slot_ff   <= out_slot_in;
         frame_done_ff <= frame_done_in;
         rsp_valid_ff  <= rsp_valid_in;
         drain_ff      <= drain_in;
         p1_ff         <= issue;
         p2_ff         <= p1_ff;
      end
   end

   // Scan and response payload registers.
   always_ff @(posedge clock) begin
      rr_ff       <= rr_in;
      r1_ff       <= r1_in;
      slot_ff     <= slot_in;
      c0_ff       <= c0_in;
      c1_ff       <= c1_in;
      x_ff        <= x_in;
      k_ff        <= k_in;
      best_ff     <= best_in;
      win_ff      <= win_in;
      rsp_disp_ff <= rsp_disp_in;
      rsp_last_ff <= rsp_last_in;
      left_ff     <= left_q;
   end

   // Line stores of both images, read at one shared address.
   sbm_ram #(.WIDTH(PIX_W), .DEPTH(STORE_DEPTH)) u_left_store (
      .clock      (clock),
      .write_en   (store_we),
      .write_addr (store_waddr),
      .write_data (req_chan.left_pixel),
      .read_addr  (store_raddr),
      .read_data  (left_q)
   );

   sbm_ram #(.WIDTH(PIX_W), .DEPTH(STORE_DEPTH)) u_right_store (
      .clock      (clock),
      .write_en   (store_we),
      .write_addr (store_waddr),
      .write_data (req_chan.right_pixel),
      .read_addr  (store_raddr),
      .read_data  (right_q)
   );

   // Chain of disparity cells: cell d sees the right pixel d columns back.
   assign cell_ctrl.clear      = clear_cells;
   assign cell_ctrl.accumulate = p2_ff.active && p2_ff.luse;
   assign cell_ctrl.shift_cost = (state_ff == ST_PICK);
   assign cell_ctrl.left_pixel = left_ff;

   assign chain_pixel[0]             = right_q;
   assign chain_valid[0]             = p1_ff.active && p1_ff.rvalid;
   assign chain_cost[MAX_DISPARITY]  = '0;

   for (genvar d = 0; d < MAX_DISPARITY; d++) begin : g_cell
      logic [COST_W-1:0] cell_cost;
      sbm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .prev_pixel (chain_pixel[d]),
         .prev_valid (chain_valid[d]),
         .next_cost  (chain_cost[d+1]),
         .pixel      (chain_pixel[d+1]),
         .valid      (chain_valid[d+1]),
         .cost       (cell_cost)
      );
      assign chain_cost[d] = cell_cost;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.disparity     = rsp_disp_ff;
   assign rsp_chan.last_of_frame = rsp_last_ff;

endmodule

// ===== hdl/sbm_checker.sv =====
// Port-level assertions for the SAD stereo disparity top level, with its bind.
module sbm_checker import sbm_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [DISP_W-1:0] rsp_disparity,
   input logic              rsp_last
);

   // A response that is not taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_disparity) && $stable(rsp_last))
      else $error("response payload changed while stalled");

   // The block works on one transaction at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous one in progress");

   // After reset the block is idle with no response pending.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("block not idle after reset");

endmodule

bind sad_block_matching_disparity_top sbm_checker u_sbm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_disparity (rsp_chan.disparity),
   .rsp_last      (rsp_chan.last_of_frame)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench of the SAD block-matching stereo disparity block.
module tb_top import sbm_pkg::*; ();

   localparam int END_WAIT_CYCLES = 3000;

   typedef struct {
      logic [DISP_W-1:0] disparity;
      logic              last_of_frame;
   } disparity_result_type;

   // Scoreboard: a bit-accurate disparity predictor and the queue of results it expects.
   class disparity_scoreboard;
      logic [PIX_W-1:0]     left_mem [STORE_DEPTH];
      logic [PIX_W-1:0]     right_mem[STORE_DEPTH];
      int                   in_row, in_col, out_row, out_col;
      bit                   frame_written;
      int                   cfg_width, cfg_height, cfg_radius, cfg_count;
      disparity_result_type expected_results[$];
      int                   error_count;
      int                   result_count;
      int                   nonzero_count;

      function void clear_state();
         in_row = 0; in_col = 0; out_row = 0; out_col = 0;
         frame_written = 0;
         cfg_width = 640; cfg_height = 480; cfg_radius = 3; cfg_count = 64;
      endfunction

      function void apply_config(csr_index_type idx, int value);
         case (idx)
            CSR_IMAGE_WIDTH:     cfg_width  = value & 'h7ff;
            CSR_IMAGE_HEIGHT:    cfg_height = value & 'h7ff;
            CSR_WINDOW_RADIUS:   cfg_radius = value & 'h7;
            CSR_DISPARITY_COUNT: cfg_count  = value & 'h7f;
            default: ;
         endcase
      endfunction

      function int eff_width();
         if (cfg_width == 0) return 1;
         return (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
      endfunction

      function int eff_height();
         if (cfg_height == 0) return 1;
         return (cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : cfg_height;
      endfunction

      function int eff_radius();
         return (cfg_radius > MAX_RADIUS) ? MAX_RADIUS : cfg_radius;
      endfunction

      function int eff_count();
         return (cfg_count > MAX_DISPARITY) ? MAX_DISPARITY : cfg_count;
      endfunction

      function int mem_addr(int row, int col);
         if (col >= MAX_WIDTH) col = MAX_WIDTH - 1;
         return (row % STORE_ROWS) * MAX_WIDTH + col;
      endfunction

      // Winner-take-all search over the clipped window; lowest disparity wins ties.
      function int winning_disparity(int row, int col);
         int w, h, rad, side, best, win, r0, r1, c0, c1, cost, lv, rv;
         w = eff_width(); h = eff_height(); rad = eff_radius();
         side = 2 * rad + 1;
         best = COST_PER_TAP * side * side;
         win = 0;
         r0 = (row >= rad) ? row - rad : 0;
         r1 = (row + rad < h) ? row + rad : h - 1;
         c0 = (col >= rad) ? col - rad : 0;
         c1 = (col + rad < w) ? col + rad : w - 1;
         for (int d = 0; d < eff_count(); d++) begin
            if (col + d > w) break;
            cost = 0;
            for (int rr = r0; rr <= r1; rr++) begin
               for (int cc = c0; cc <= c1; cc++) begin
                  if (cc < d) continue;
                  lv = int'(left_mem[mem_addr(rr, cc)]);
                  rv = int'(right_mem[mem_addr(rr, cc - d)]);
                  cost += (lv > rv) ? lv - rv : rv - lv;
               end
            end
            if (cost < best) begin
               best = cost;
               win = d;
            end
         end
         return win;
      endfunction

      // Notes one accepted request transaction and queues the result it causes, if any.
      function void note_input(logic mode, logic [PIX_W-1:0] lpix, logic [PIX_W-1:0] rpix);
         int w, h, rad, nr, nc;
         disparity_result_type res;
         w = eff_width(); h = eff_height(); rad = eff_radius();
         if (mode == 1'b0) begin
            if (frame_written) begin
               out_row = 0; out_col = 0;
               frame_written = 0;
            end
            left_mem[mem_addr(in_row, in_col)]  = lpix;
            right_mem[mem_addr(in_row, in_col)] = rpix;
            in_col++;
            if (in_col >= w) begin
               in_col = 0;
               in_row++;
               if (in_row >= h) begin
                  in_row = 0;
                  frame_written = 1;
               end
            end
         end
         nr = (out_row + rad < h) ? out_row + rad : h - 1;
         nc = (out_col + rad < w) ? out_col + rad : w - 1;
         if (!(frame_written || in_row > nr || (in_row == nr && in_col > nc))) return;
         res.disparity = DISP_W'(winning_disparity(out_row, out_col));
         res.last_of_frame = 1'b0;
         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row++;
            if (out_row >= h) begin
               out_row = 0;
               res.last_of_frame = 1'b1;
               frame_written = 0;
            end
         end
         expected_results.push_back(res);
      endfunction

      // Results still owed for a frame whose pixels have all arrived.
      function int results_to_drain();
         if (!frame_written) return 0;
         return eff_width() * eff_height() - (out_row * eff_width() + out_col);
      endfunction

      // Compares one accepted response transaction with the oldest expectation.
      function void check_result(logic [DISP_W-1:0] disparity, logic last_of_frame);
         disparity_result_type exp_res;
         result_count++;
         if (disparity != 0) nonzero_count++;
         if (expected_results.size() == 0) begin
            $error("unexpected result: disparity %0d last_of_frame %0d",
                   disparity, last_of_frame);
            error_count++;
            return;
         end
         exp_res = expected_results.pop_front();
         if (disparity !== exp_res.disparity) begin
            $error("disparity: expected %0d, actual %0d", exp_res.disparity, disparity);
            error_count++;
         end
         if (last_of_frame !== exp_res.last_of_frame) begin
            $error("last_of_frame: expected %0d, actual %0d",
                   exp_res.last_of_frame, last_of_frame);
            error_count++;
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_write_data;

   sbm_req_if req_if();
   sbm_rsp_if rsp_if();

   disparity_scoreboard disparity_sb;
   bit                  no_idle;
   int                  pixel_count;
   int                  frame_count;
   int                  phase_count;

   sad_block_matching_disparity_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_if),
      .rsp_chan       (rsp_if),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // Clock generation.
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly short gaps, a few long ones, none at all while no_idle is set.
   function automatic int random_gap();
      int pick;
      if (no_idle) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offers one request transaction and returns once it has been accepted.
   task automatic send_item(logic mode, logic [PIX_W-1:0] lpix, logic [PIX_W-1:0] rpix);
      int gap;
      gap = random_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.mode        <= mode;
      req_if.left_pixel  <= lpix;
      req_if.right_pixel <= rpix;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      disparity_sb.note_input(mode, lpix, rpix);
      if (mode == 1'b0) pixel_count++;
   endtask

   // Lowers valid and waits until every expected result has arrived.
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (disparity_sb.expected_results.size() != 0) @(posedge clock);
   endtask

   // Writes all four registers once the block is idle.
   task automatic configure(int w, int h, int rad, int dcount);
      int values[4];
      values = '{w, h, rad, dcount};
      wait_drained();
      repeat (END_WAIT_CYCLES) @(posedge clock);
      for (int i = 0; i < 4; i++) begin
         csr_write_en   <= 1'b1;
         csr_index      <= csr_index_type'(i);
         csr_write_data <= CSR_W'(values[i]);
         disparity_sb.apply_config(csr_index_type'(i), values[i]);
         @(posedge clock);
      end
      csr_write_en <= 1'b0;
      phase_count++;
   endtask

   // Sends one frame whose right image is the left image shifted, with noise, or in some frames random.
   task automatic send_frame(bit drain, bit extremes);
      int w, h, shift, noisy, v;
      logic [PIX_W-1:0] lrow[$];
      logic [PIX_W-1:0] rpix;
      w = disparity_sb.eff_width();
      h = disparity_sb.eff_height();
      shift = $urandom_range(0, (w < 20) ? w : 20);
      noisy = ($urandom_range(0, 3) == 0);
      for (int r = 0; r < h; r++) begin
         lrow.delete();
         for (int c = 0; c < w + shift; c++) begin
            if (extremes) lrow.push_back($urandom_range(0, 1) ? 8'hff : 8'h00);
            else lrow.push_back(PIX_W'($urandom_range(0, 255)));
         end
         for (int c = 0; c < w; c++) begin
            // The right pixel at column c shows the left pixel at column c - shift.
            v = (c >= shift) ? lrow[c - shift] + $urandom_range(0, 6) - 3
                             : $urandom_range(0, 255);
            if (noisy) v = $urandom_range(0, 255);
            rpix = (v < 0) ? 8'h00 : (v > 255) ? 8'hff : PIX_W'(v);
            // Now and then a flush lands in the middle of the frame.
            if ($urandom_range(0, 19) == 0)
               send_item(1'b1, PIX_W'($urandom), PIX_W'($urandom));
            send_item(1'b0, lrow[c], rpix);
         end
      end
      frame_count++;
      if (drain) begin
         repeat (disparity_sb.results_to_drain())
            send_item(1'b1, PIX_W'($urandom), PIX_W'($urandom));
         // A flush with nothing pending causes no result.
         if ($urandom_range(0, 1)) send_item(1'b1, PIX_W'($urandom), PIX_W'($urandom));
      end
   endtask

   // Response side: random stalls, and one long hold-off so the block backs up.
   initial begin
      int stall;
      bit held;
      held = 0;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (1) begin
         if (!held && disparity_sb.result_count >= 40) begin
            held = 1;
            rsp_if.ready <= 1'b0;
            repeat (4000) @(posedge clock);
         end
         stall = no_idle ? 0 : random_gap();
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         disparity_sb.check_result(rsp_if.disparity, rsp_if.last_of_frame);
   end

   // Overall time limit.
   initial begin
      #200000000;
      $display("sad_block_matching_disparity_top: mismatch");
      $finish;
   end

   // Main stimulus.
   initial begin
      int w, h, rad;
      disparity_sb = new();
      disparity_sb.clear_state();
      no_idle = 0;
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = CSR_IMAGE_WIDTH;
      csr_write_data = '0;
      req_if.valid = 1'b0;
      req_if.mode = 1'b0;
      req_if.left_pixel = '0;
      req_if.right_pixel = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: saturated pixels, an early flush, then the size and count extremes.
      configure(5, 4, 1, 8);
      send_item(1'b1, 8'hff, 8'h00);
      send_frame(1, 1);
      configure(0, 0, 0, 0);
      send_frame(0, 0);
      send_frame(1, 0);
      configure(2047, 1, 0, 64);
      send_frame(1, 0);
      configure(1, 40, 0, 1);
      send_frame(1, 0);
      configure(12, 6, 7, 127);
      send_frame(0, 0);
      send_frame(1, 0);

      // Random phases, mostly small windows, frames sometimes cut short by the next one.
      while (pixel_count < 1400) begin
         no_idle = ($urandom_range(0, 4) == 0);
         w = $urandom_range(1, 24);
         h = $urandom_range(1, 10);
         rad = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 2);
         configure(w, h, rad, $urandom_range(0, 127));
         repeat ($urandom_range(1, 4)) send_frame($urandom_range(0, 2) != 0, 0);
         send_frame(1, 0);
      end

      // End of run: everything back, then let the block settle.
      no_idle = 0;
      wait_drained();
      repeat (END_WAIT_CYCLES) @(posedge clock);
      $display("Covered %0d phases, %0d frames, %0d pixels; %0d results, %0d nonzero.",
               phase_count, frame_count, pixel_count,
               disparity_sb.result_count, disparity_sb.nonzero_count);
      if (disparity_sb.error_count == 0 && disparity_sb.expected_results.size() == 0) begin
         $display("sad_block_matching_disparity_top: match");
      end else begin
         $display("sad_block_matching_disparity_top: mismatch");
      end
      $finish;
   end

endmodule
